[design/kcs_pkg.sv]
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared constants, types and helper functions for the keyword command screen:
// keyword text, cell placement and control structs.
// ----------------------------------------------------------------------------
package kcs_pkg;

  localparam int COUNT_BITS = 32;
  localparam int TOTAL_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int NUM_KEYS   = 6;
  localparam int NUM_CELLS  = 74;

  localparam int KEY_LEN [NUM_KEYS] = '{12, 4, 4, 32, 14, 8};

  // rate-cap command keyword
  localparam logic [CHAR_W*12-1:0] KW_RATE_CAP = {
    8'h6d, 8'h61, 8'h78, 8'h5f, 8'h74, 8'h68,
    8'h72, 8'h6f, 8'h74, 8'h74, 8'h6c, 8'h65
  };

  // all keywords back to back, first character at the top
  localparam logic [CHAR_W*NUM_CELLS-1:0] KEY_TEXT = {
    KW_RATE_CAP,
    "drop",
    "fuzz",
    "ignore all previous instructions",
    "system failure",
    "override"
  };

  localparam logic [CHAR_W-1:0] UPPER_A   = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z   = 8'h5a;
  localparam logic [CHAR_W-1:0] CASE_STEP = 8'h20;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [TOTAL_W-1:0]    total_t;
  typedef logic [CHAR_W-1:0]     char_t;

  typedef struct packed {
    logic step;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic byte_valid;
    logic end_of_command;
    logic null_command;
  } req_flags_t;

  function automatic char_t fold_case(input char_t c);
    char_t r;
    r = c;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_STEP;
    end
    return r;
  endfunction

  function automatic char_t key_char(input int j);
    return KEY_TEXT[CHAR_W*(NUM_CELLS-1-j) +: CHAR_W];
  endfunction

  function automatic logic is_first(input int j);
    int   base;
    logic r;
    base = 0;
    r    = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (j == base) r = 1'b1;
      base = base + KEY_LEN[k];
    end
    return r;
  endfunction

  function automatic logic [NUM_CELLS-1:0] last_mask();
    int                   base;
    logic [NUM_CELLS-1:0] m;
    base = 0;
    m    = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      base = base + KEY_LEN[k];
      m[base-1] = 1'b1;
    end
    return m;
  endfunction

endpackage

[design/kcs_if.sv]
// ----------------------------------------------------------------------------
// kcs_if
// Valid/ready channels of the keyword command screen: command bytes in,
// verdicts out.
// ----------------------------------------------------------------------------
interface kcs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       byte_valid;
  logic       end_of_command;
  logic       null_command;

  modport source (output valid, output char_byte, output byte_valid,
                  output end_of_command, output null_command, input ready);
  modport sink   (input valid, input char_byte, input byte_valid,
                  input end_of_command, input null_command, output ready);
endinterface

interface kcs_out_if;
  logic        valid;
  logic        ready;
  logic        verdict;
  logic [31:0] blocked_total;

  modport source (output valid, output verdict, output blocked_total, input ready);
  modport sink   (input valid, input verdict, input blocked_total, output ready);
endinterface

[design/keyword_command_screen_top.sv]
// ----------------------------------------------------------------------------
// keyword_command_screen_top
// Screens command strings, one byte per request, for six fixed keywords,
// case-insensitive, anywhere in the command; one verdict per command.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   char_byte, byte_valid, end_of_command,
//                               null_command
//   out_ch   out  valid/ready   verdict, blocked_total
//
// One request per cycle while in_ch.ready is high; a verdict is registered
// when its last byte is taken. The match state is a chain of 74 one-bit cells,
// one per keyword character, all updated together in the cycle a byte is taken.
// Reset is synchronous, active low; it clears the match state, the counter
// and the output stage. A stalled output holds one verdict in the output
// register and one in a skid entry; in_ch.ready drops only when both are full.
// ----------------------------------------------------------------------------
module keyword_command_screen_top
  import kcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  kcs_in_if.sink   in_ch,
  kcs_out_if.source out_ch
);

  localparam logic [NUM_CELLS-1:0] LAST_MASK = last_mask();

  logic                 acc;
  logic                 ready;
  char_t                ch;
  cell_ctrl_t           ctrl;
  req_flags_t           flags;
  logic [NUM_CELLS-1:0] match;
  logic [NUM_CELLS-1:0] prev;
  logic [NUM_CELLS-1:0] hit_v;
  logic                 hit;

  assign acc = in_ch.valid && ready;
  assign ch  = fold_case(in_ch.char_byte);

  assign flags.byte_valid     = in_ch.byte_valid;
  assign flags.end_of_command = in_ch.end_of_command;
  assign flags.null_command   = in_ch.null_command;

  // a verdict or an absent command wipes the partial matches
  assign ctrl.clear = acc && (in_ch.null_command || in_ch.end_of_command);
  assign ctrl.step  = acc && in_ch.byte_valid && !ctrl.clear;

  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    if (j == 0) begin : g_head
      assign prev[j] = 1'b0;
    end else begin : g_link
      assign prev[j] = match[j-1];
    end

    kcs_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .ch     (ch),
      .key_ch (key_char(j)),
      .first  (is_first(j)),
      .prev   (prev[j]),
      .match  (match[j]),
      .hit    (hit_v[j])
    );
  end

  // full keyword matched on this byte
  assign hit = |(hit_v & LAST_MASK);

  kcs_verdict u_verdict (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .flags    (flags),
    .hit      (hit),
    .in_ready (ready),
    .out_ch   (out_ch)
  );

  assign in_ch.ready = ready;

endmodule

[design/kcs_cell.sv]
// ----------------------------------------------------------------------------
// kcs_cell
// One shift-and match bit: holds whether the recent bytes equal a keyword
// prefix ending at this character, and passes it to the next cell.
// ----------------------------------------------------------------------------
module kcs_cell
  import kcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  char_t      ch,
  input  char_t      key_ch,
  input  logic       first,
  input  logic       prev,
  output logic       match,
  output logic       hit
);

  logic match_r;
  logic match_nxt;

  // first cell of a keyword always has an open prefix behind it
  assign hit = (first | prev) & (ch == key_ch);

  always_comb begin
    match_nxt = match_r;
    if (ctrl.clear) begin
      match_nxt = 1'b0;
    end else if (ctrl.step) begin
      match_nxt = hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign match = match_r;

endmodule

[design/kcs_verdict.sv]
// ----------------------------------------------------------------------------
// kcs_verdict
// Keeps the keyword-seen flag and the saturating blocked counter, forms one
// verdict per command and holds it in an output register with a skid entry.
// ----------------------------------------------------------------------------
module kcs_verdict
  import kcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  req_flags_t flags,
  input  logic       hit,
  output logic       in_ready,
  kcs_out_if.source  out_ch
);

  logic   seen_r, seen_nxt;
  count_t cnt_r, cnt_nxt;
  logic   out_v_r, out_v_nxt;
  logic   out_verdict_r, out_verdict_nxt;
  total_t out_total_r, out_total_nxt;
  logic   skid_v_r, skid_v_nxt;
  logic   skid_verdict_r, skid_verdict_nxt;
  total_t skid_total_r, skid_total_nxt;

  logic   produce;
  logic   seen_now;
  logic   res_verdict;
  total_t res_total;

  assign produce  = acc && (flags.null_command || flags.end_of_command);
  assign seen_now = seen_r | (flags.byte_valid & hit);
  assign in_ready = !skid_v_r;

  always_comb begin
    seen_nxt    = seen_r;
    cnt_nxt     = cnt_r;
    res_verdict = 1'b1;
    if (acc) begin
      priority if (flags.null_command) begin
        seen_nxt    = 1'b0;
        res_verdict = 1'b0;
      end else if (flags.end_of_command) begin
        seen_nxt    = 1'b0;
        res_verdict = !seen_now;
        if (seen_now && (cnt_r != '1)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end else if (flags.byte_valid) begin
        seen_nxt = seen_now;
      end
    end
    res_total = TOTAL_W'(cnt_nxt);
  end

  // output register with one skid entry
  always_comb begin
    out_v_nxt        = out_v_r;
    out_verdict_nxt  = out_verdict_r;
    out_total_nxt    = out_total_r;
    skid_v_nxt       = skid_v_r;
    skid_verdict_nxt = skid_verdict_r;
    skid_total_nxt   = skid_total_r;
    if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_nxt       = 1'b1;
        out_verdict_nxt = skid_verdict_r;
        out_total_nxt   = skid_total_r;
        skid_v_nxt      = 1'b0;
      end else begin
        out_v_nxt       = produce;
        out_verdict_nxt = res_verdict;
        out_total_nxt   = res_total;
      end
    end else if (produce) begin
      skid_v_nxt       = 1'b1;
      skid_verdict_nxt = res_verdict;
      skid_total_nxt   = res_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 1'b0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      seen_r   <= seen_nxt;
      cnt_r    <= cnt_nxt;
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_verdict_r  <= out_verdict_nxt;
    out_total_r    <= out_total_nxt;
    skid_verdict_r <= skid_verdict_nxt;
    skid_total_r   <= skid_total_nxt;
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.verdict       = out_verdict_r;
  assign out_ch.blocked_total = out_total_r;

endmodule

[design/kcs_checker.sv]
// ----------------------------------------------------------------------------
// kcs_checker
// Port-level checks on the keyword command screen, bound to the top level.
// ----------------------------------------------------------------------------
module kcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_null,
  input logic        in_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_verdict,
  input logic [31:0] out_total
);

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("verdict present after reset");

  // back-pressure only when a verdict is already waiting
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // absent command on an empty output gives a reject the next cycle
  a_null_reject: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_null && !out_valid |=> out_valid && !out_verdict)
    else $error("absent command did not reject");

  // mid-command request on an empty output gives no verdict
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_null && !in_end && !out_valid |=> !out_valid)
    else $error("verdict without end of command");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict) && $stable(out_total))
    else $error("stalled verdict changed");

endmodule

bind keyword_command_screen_top kcs_checker u_kcs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_null     (in_ch.null_command),
  .in_end      (in_ch.end_of_command),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_verdict (out_ch.verdict),
  .out_total   (out_ch.blocked_total)
);
